// File: rtl/u8dec_pkg.sv
// u8dec_pkg: types, status codes and decode helpers for the UTF-8 stream decoder.
// No dependencies; imported by utf8_stream_decoder_unit, utf8_dec_checker and the testbench.
package u8dec_pkg;

    localparam int RUNE_W  = 31;
    localparam int LEN_W   = 3;
    localparam int ST_W    = 3;
    localparam int ODATA_W = 40;

    localparam logic [RUNE_W-1:0] RUNE_RESET = 31'h0000FFFD;

    // Status codes of a result item
    localparam logic [ST_W-1:0] ST_OK         = 3'd0;
    localparam logic [ST_W-1:0] ST_BAD_LEAD   = 3'd1;
    localparam logic [ST_W-1:0] ST_BROKEN     = 3'd2;
    localparam logic [ST_W-1:0] ST_OVERLONG   = 3'd3;
    localparam logic [ST_W-1:0] ST_INCOMPLETE = 3'd4;

    // Kinds of a byte taken in lead position
    localparam logic [1:0] LK_ASCII = 2'd0;
    localparam logic [1:0] LK_OPEN  = 2'd1;
    localparam logic [1:0] LK_BAD   = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [LEN_W-1:0] len;
        logic [5:0]       bits;
    } lead_t;

    typedef struct packed {
        logic [RUNE_W-1:0] code_point;
        logic [ST_W-1:0]   status;
        logic [LEN_W-1:0]  bytes_used;
        logic              last;
    } result_t;

    // Classify a byte in lead position and pull out its payload bits
    function automatic lead_t lead_decode(input logic [7:0] b);
        lead_t r;
        r.kind = LK_OPEN;
        r.len  = 3'd0;
        r.bits = 6'd0;
        if (b[7] == 1'b0) begin
            r.kind = LK_ASCII;
            r.len  = 3'd1;
        end else if (b[7:5] == 3'b110) begin
            r.len  = 3'd2;
            r.bits = {1'b0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            r.len  = 3'd3;
            r.bits = {2'b0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            r.len  = 3'd4;
            r.bits = {3'b0, b[2:0]};
        end else if (b[7:2] == 6'b111110) begin
            r.len  = 3'd5;
            r.bits = {4'b0, b[1:0]};
        end else if (b[7:1] == 7'b1111110) begin
            r.len  = 3'd6;
            r.bits = {5'b0, b[0]};
        end else begin
            r.kind = LK_BAD;
            r.len  = 3'd1;
        end
        return r;
    endfunction

    // Shortest encoding length of a code point
    function automatic logic [LEN_W-1:0] min_length(input logic [RUNE_W-1:0] r);
        logic [LEN_W-1:0] n;
        if (r < 31'h80)             n = 3'd1;
        else if (r < 31'h800)       n = 3'd2;
        else if (r < 31'h10000)     n = 3'd3;
        else if (r < 31'h200000)    n = 3'd4;
        else if (r < 31'h4000000)   n = 3'd5;
        else                        n = 3'd6;
        return n;
    endfunction

endpackage

// File: rtl/utf8_stream_decoder_unit.sv
// utf8_stream_decoder_unit: byte-serial decoder for 1-to-6-byte UTF-8, top level.
// Depends on u8dec_pkg for types, status codes and the lead/min-length helpers.
//
// One byte is accepted per cycle and decoded in the same cycle against the open
// sequence state; its results (zero, one or two) go into a four-entry result
// queue that feeds the master side, one result per cycle while m_tready is high. A byte is accepted
// whenever the queue has room for two results, so with a ready consumer the
// decoder sustains one byte per clock until bytes that yield two results fill the
// queue. Results are registered into the queue when their byte is accepted.
// The replacement rune is written through the cfg channel, which is always
// ready, and must only be changed while idle.
module utf8_stream_decoder_unit
    import u8dec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // Input bytes
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] in_byte
    input  logic              s_tlast,   // end_of_buffer
    // Results
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [ODATA_W-1:0] m_tdata,  // [30:0] code_point, [33:31] status,
                                         // [36:34] bytes_used, [39:37] zero
    output logic              m_tlast,   // last_of_run
    // Replacement rune register
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [RUNE_W-1:0] cfg_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;
    localparam int CNT_W = 3;

    logic [RUNE_W-1:0] repl_reg;
    logic [RUNE_W-1:0] part_reg, part_next;
    logic [LEN_W-1:0]  exp_reg, exp_next;
    logic [LEN_W-1:0]  seen_reg, seen_next;

    result_t           q_mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              s_acc, m_acc;
    logic [7:0]        b;
    logic              is_cont;
    lead_t             ld;
    logic [RUNE_W-1:0] cont_part;
    logic [LEN_W-1:0]  cont_seen;
    logic              use_lead;

    result_t           res_a, res_b, res_c, res_bc, r0, r1;
    logic              va, vb, vc, vbc;
    logic [1:0]        n_wr;

    assign cfg_ready = 1'b1;
    assign s_tready  = (cnt_reg <= CNT_W'(DEPTH - 2));
    assign s_acc     = s_tvalid && s_tready;
    assign m_acc     = m_tvalid && m_tready;
    assign b         = s_tdata;
    assign is_cont   = (b[7:6] == 2'b10);
    assign ld        = lead_decode(b);
    assign cont_part = {part_reg[RUNE_W-7:0], b[5:0]};
    assign cont_seen = seen_reg + 3'd1;

    // Decode one byte: broken-sequence result, sequence/lead result, incomplete result
    always_comb
    begin
        part_next = part_reg;
        exp_next  = exp_reg;
        seen_next = seen_reg;
        va = 1'b0;
        vb = 1'b0;
        vc = 1'b0;
        res_a = '{code_point: repl_reg, status: ST_BROKEN, bytes_used: seen_reg, last: 1'b0};
        res_b = '{code_point: repl_reg, status: ST_BAD_LEAD, bytes_used: 3'd1, last: 1'b0};
        use_lead = 1'b0;

        if (exp_reg == 3'd0) begin
            use_lead = 1'b1;
        end else if (is_cont) begin
            part_next = cont_part;
            seen_next = cont_seen;
            if (cont_seen >= exp_reg) begin
                vb = 1'b1;
                res_b.bytes_used = exp_reg;
                if (min_length(cont_part) < exp_reg) begin
                    res_b.status = ST_OVERLONG;
                end else begin
                    res_b.status     = ST_OK;
                    res_b.code_point = cont_part;
                end
                part_next = '0;
                exp_next  = '0;
                seen_next = '0;
            end
        end else begin
            va        = 1'b1;
            use_lead  = 1'b1;
            part_next = '0;
            exp_next  = '0;
            seen_next = '0;
        end

        // Byte in lead position
        if (use_lead) begin
            case (ld.kind)
                LK_ASCII:
                begin
                    vb = 1'b1;
                    res_b.status     = ST_OK;
                    res_b.code_point = {23'd0, b};
                end
                LK_OPEN:
                begin
                    part_next = {25'd0, ld.bits};
                    exp_next  = ld.len;
                    seen_next = 3'd1;
                end
                default:
                begin
                    vb = 1'b1;
                end
            endcase
        end

        // End of buffer closes an open sequence
        res_c = '{code_point: repl_reg, status: ST_INCOMPLETE, bytes_used: seen_next,
                  last: 1'b0};
        if (s_tlast && (exp_next != 3'd0)) begin
            vc        = 1'b1;
            part_next = '0;
            exp_next  = '0;
            seen_next = '0;
        end
    end

    // Compact the result slots; the middle and end-of-buffer results never coincide
    always_comb
    begin
        vbc    = vb || vc;
        res_bc = vb ? res_b : res_c;
        r0     = va ? res_a : res_bc;
        r1     = res_bc;
        r0.last = !(va && vbc);
        r1.last = 1'b1;
        n_wr   = {1'b0, va} + {1'b0, vbc};
    end

    // Sequence state and replacement rune
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            repl_reg <= RUNE_RESET;
            part_reg <= '0;
            exp_reg  <= '0;
            seen_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                repl_reg <= cfg_data;
            end
            if (s_acc) begin
                part_reg <= part_next;
                exp_reg  <= exp_next;
                seen_reg <= seen_next;
            end
        end
    end

    // Result queue storage
    always_ff @(posedge clk)
    begin
        if (s_acc && (n_wr != 2'd0)) begin
            q_mem[wr_ptr_reg] <= r0;
            if (n_wr == 2'd2) begin
                q_mem[wr_ptr_reg + PTR_W'(1)] <= r1;
            end
        end
    end

    // Result queue pointers and fill count
    always_comb
    begin
        cnt_next = cnt_reg + (s_acc ? CNT_W'(n_wr) : CNT_W'(0)) - CNT_W'(m_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (s_acc) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_wr);
            end
            if (m_acc) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    // Master side
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {3'd0, q_mem[rd_ptr_reg].bytes_used, q_mem[rd_ptr_reg].status,
                       q_mem[rd_ptr_reg].code_point};
    assign m_tlast  = q_mem[rd_ptr_reg].last;

    // Checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("result queue overfilled");

    a_room_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |-> (cnt_reg <= CNT_W'(DEPTH - 2)))
        else $error("byte accepted without room for two results");

    a_idle_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (exp_reg == 3'd0) |-> (seen_reg == 3'd0) && (part_reg == '0))
        else $error("sequence counters set with no sequence open");

    a_seen_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (exp_reg != 3'd0) |-> (seen_reg < exp_reg) && (seen_reg != 3'd0)
                              && (exp_reg >= 3'd2) && (exp_reg <= 3'd6))
        else $error("open sequence count out of range");

endmodule

// File: verif/utf8_dec_checker.sv
// utf8_dec_checker: watches the byte, result and rune-register channels of
// utf8_stream_decoder_unit, predicts every result item and compares them in order.
// Depends on u8dec_pkg for widths, the result struct and the status codes.
module utf8_dec_checker
    import u8dec_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [7:0]         s_tdata,    // [7:0] in_byte
    input  logic               s_tlast,    // end_of_buffer
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [ODATA_W-1:0] m_tdata,    // [30:0] code_point, [33:31] status,
                                           // [36:34] bytes_used, [39:37] zero
    input  logic               m_tlast,    // last_of_run
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [RUNE_W-1:0]  cfg_data,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow of the decoder state and the rune register
    logic [RUNE_W-1:0] rune_reg;
    logic [RUNE_W-1:0] gathered;
    logic [LEN_W-1:0]  seq_len;
    logic [LEN_W-1:0]  seq_seen;

    result_t expected_results[$];
    result_t byte_results[$];

    // Length of the shortest encoding of a code point
    function automatic logic [LEN_W-1:0] shortest_len(input logic [RUNE_W-1:0] cp);
        logic [LEN_W-1:0] n;
        if (cp < 31'h80)           n = 3'd1;
        else if (cp < 31'h800)     n = 3'd2;
        else if (cp < 31'h10000)   n = 3'd3;
        else if (cp < 31'h200000)  n = 3'd4;
        else if (cp < 31'h4000000) n = 3'd5;
        else                       n = 3'd6;
        return n;
    endfunction

    function automatic void add_result(input logic [RUNE_W-1:0] cp,
                                       input logic [ST_W-1:0] st,
                                       input logic [LEN_W-1:0] used);
        result_t r;
        r.code_point = cp;
        r.status     = st;
        r.bytes_used = used;
        r.last       = 1'b0;
        byte_results.push_back(r);
    endfunction

    function automatic void close_seq();
        gathered = '0;
        seq_len  = '0;
        seq_seen = '0;
    endfunction

    // Byte in lead position: ASCII, bad lead, or the start of a sequence
    function automatic void take_lead(input logic [7:0] b);
        logic [LEN_W-1:0] n;
        logic [5:0]       payload;
        n = '0;
        payload = '0;
        casez (b)
            8'b0???????: add_result({23'd0, b}, ST_OK, 3'd1);
            8'b110?????: begin n = 3'd2; payload = {1'b0, b[4:0]}; end
            8'b1110????: begin n = 3'd3; payload = {2'b0, b[3:0]}; end
            8'b11110???: begin n = 3'd4; payload = {3'b0, b[2:0]}; end
            8'b111110??: begin n = 3'd5; payload = {4'b0, b[1:0]}; end
            8'b1111110?: begin n = 3'd6; payload = {5'b0, b[0]}; end
            default:     add_result(rune_reg, ST_BAD_LEAD, 3'd1);
        endcase
        if (n != 0)
        begin
            gathered = {25'd0, payload};
            seq_len  = n;
            seq_seen = 3'd1;
        end
    endfunction

    // Work out the results of one accepted byte and queue them
    function automatic void decode_byte(input logic [7:0] b, input logic eob);
        byte_results.delete();
        if (seq_len == 0)
            take_lead(b);
        else if (b[7:6] == 2'b10)
        begin
            gathered = {gathered[RUNE_W-7:0], b[5:0]};
            seq_seen = seq_seen + 3'd1;
            if (seq_seen >= seq_len)
            begin
                if (shortest_len(gathered) < seq_len)
                    add_result(rune_reg, ST_OVERLONG, seq_len);
                else
                    add_result(gathered, ST_OK, seq_len);
                close_seq();
            end
        end
        else
        begin
            // interrupted sequence, then the byte starts over as a lead
            add_result(rune_reg, ST_BROKEN, seq_seen);
            close_seq();
            take_lead(b);
        end
        // buffer ends with a sequence still open
        if (eob && seq_len != 0)
        begin
            add_result(rune_reg, ST_INCOMPLETE, seq_seen);
            close_seq();
        end
        if (byte_results.size() > 0)
            byte_results[byte_results.size()-1].last = 1'b1;
        foreach (byte_results[i])
            expected_results.push_back(byte_results[i]);
    endfunction

    // Compare one result item with the oldest expectation
    function automatic void check_result();
        result_t got;
        result_t want;
        got.code_point = m_tdata[30:0];
        got.status     = m_tdata[33:31];
        got.bytes_used = m_tdata[36:34];
        got.last       = m_tlast;
        if (expected_results.size() == 0)
        begin
            fail_count++;
            $display("%0t: unexpected result cp=%h status=%0d used=%0d last=%0d",
                     $time, got.code_point, got.status, got.bytes_used, got.last);
        end
        else
        begin
            want = expected_results.pop_front();
            if (got.code_point !== want.code_point || got.status !== want.status ||
                got.bytes_used !== want.bytes_used || got.last !== want.last ||
                m_tdata[39:37] !== 3'b000)
            begin
                fail_count++;
                $display("%0t: result mismatch expected cp=%h status=%0d used=%0d last=%0d",
                         $time, want.code_point, want.status, want.bytes_used, want.last);
                $display("%0t:                 actual   cp=%h status=%0d used=%0d last=%0d pad=%b",
                         $time, got.code_point, got.status, got.bytes_used, got.last,
                         m_tdata[39:37]);
            end
        end
    endfunction

    // Results are checked before the same edge's byte is predicted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rune_reg = RUNE_RESET;
            close_seq();
            expected_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                rune_reg = cfg_data;
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tlast);
        end
        pending = expected_results.size();
    end

endmodule

// File: verif/tb_utf8_stream_decoder_unit.sv
// tb_utf8_stream_decoder_unit: drives bytes and rune-register writes into the decoder,
// applies receiver back-pressure and gives the verdict.
// Depends on u8dec_pkg, utf8_stream_decoder_unit and utf8_dec_checker.
module tb_utf8_stream_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import u8dec_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_CYCLES = 4;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [ODATA_W-1:0] m_tdata;
    logic               m_tlast;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [RUNE_W-1:0]  cfg_data;

    int fail_count;
    int pending;

    typedef struct {
        logic [7:0] value;
        logic       eob;
    } tx_byte_t;

    tx_byte_t tx_q[$];

    // Sender burst control
    int burst_left;
    int gap_max;

    // Receiver control
    logic        rx_always;
    logic        hold_on;
    logic [15:0] stall_pat;
    int          pat_pos;
    int          idle_cycles;
    event        hold_ev;

    utf8_stream_decoder_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    utf8_dec_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Receiver: stall pattern refreshed once per pass through its 16 bits, or always ready, or held off
    always @(negedge clk)
    begin
        if (hold_on)
            m_tready <= 1'b0;
        else if (rx_always)
            m_tready <= 1'b1;
        else
            m_tready <= stall_pat[pat_pos];
        pat_pos = (pat_pos + 1) % 16;
        if (pat_pos == 0)
        begin
            case ($urandom_range(2))
                0:       stall_pat = 16'($urandom | $urandom);
                1:       stall_pat = 16'($urandom);
                default: stall_pat = 16'($urandom & $urandom);
            endcase
        end
    end

    // Long receiver hold-off, counted here
    always
    begin
        @(hold_ev);
        @(posedge clk);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
    end

    // Watchdog on cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // Offer one byte, in bursts with random gaps between them
    task automatic send_byte(input logic [7:0] value, input logic eob);
        int gap;
        if (burst_left == 0)
        begin
            gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 1);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(32, 1);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= eob;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic send_queued();
        foreach (tx_q[i])
            send_byte(tx_q[i].value, tx_q[i].eob);
        tx_q.delete();
    endtask

    // Stop sending until every expected result is back, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic write_rune(input logic [RUNE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void push_byte(input logic [7:0] value, input logic eob);
        tx_byte_t t;
        t.value = value;
        t.eob   = eob;
        tx_q.push_back(t);
    endfunction

    // Smallest code point whose shortest encoding has n bytes
    function automatic int unsigned rune_floor(input int n);
        case (n)
            1:       return 32'h0;
            2:       return 32'h80;
            3:       return 32'h800;
            4:       return 32'h10000;
            5:       return 32'h200000;
            default: return 32'h4000000;
        endcase
    endfunction

    // Queue the first keep bytes of the n-byte encoding of cp
    function automatic void queue_rune(input logic [30:0] cp, input int n, input int keep);
        logic [7:0] v;
        for (int i = 0; i < keep; i++)
        begin
            if (n == 1)
                v = {1'b0, cp[6:0]};
            else if (i == 0)
                v = ~(8'hFF >> n) | (8'(cp >> (6 * (n - 1))) & (8'hFF >> (n + 1)));
            else
                v = {2'b10, 6'(cp >> (6 * (n - 1 - i)))};
            push_byte(v, $urandom_range(19) == 0);
        end
    endfunction

    // Mostly well-formed sequences, plus overlong, cut-off and noise bytes
    task automatic run_random(input int n_items);
        int          sent;
        int          pick;
        int          n;
        int          keep;
        int unsigned lo;
        int unsigned hi;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                n  = $urandom_range(6, 1);
                lo = rune_floor(n);
                hi = (n == 6) ? 32'h7FFFFFFF : rune_floor(n + 1) - 1;
                queue_rune(31'($urandom_range(hi, lo)), n, n);
            end
            else if (pick < 70)
            begin
                n = $urandom_range(6, 2);
                queue_rune(31'($urandom_range(rune_floor(n) - 1, 0)), n, n);
            end
            else if (pick < 85)
            begin
                n    = $urandom_range(6, 2);
                keep = $urandom_range(n - 1, 1);
                queue_rune(31'($urandom), n, keep);
                if ($urandom_range(1) == 1)
                    tx_q[tx_q.size()-1].eob = 1'b1;
            end
            else
                push_byte(8'($urandom), $urandom_range(11) == 0);
            sent += tx_q.size();
            send_queued();
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        rx_always   = 1'b0;
        hold_on     = 1'b0;
        stall_pat   = 16'($urandom);
        pat_pos     = 0;
        idle_cycles = 0;
        burst_left  = 0;
        gap_max     = 3;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed bytes under the reset rune
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b1);   // end of buffer with nothing open
        push_byte(8'h80, 1'b0);   // stray continuation
        push_byte(8'hFE, 1'b0);   // invalid lead
        push_byte(8'hFF, 1'b0);
        push_byte(8'hC2, 1'b0);   // U+0080
        push_byte(8'h80, 1'b0);
        push_byte(8'hC1, 1'b0);   // overlong two-byte
        push_byte(8'hBF, 1'b0);
        push_byte(8'hEF, 1'b0);   // U+FFFF
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hFD, 1'b0);   // largest six-byte value
        repeat (5) push_byte(8'hBF, 1'b0);
        push_byte(8'hE0, 1'b0);   // broken by ASCII: two results
        push_byte(8'h41, 1'b0);
        push_byte(8'hF0, 1'b0);   // broken by a lead, then cut by end of buffer
        push_byte(8'hF0, 1'b1);
        push_byte(8'hC3, 1'b1);   // incomplete at end
        push_byte(8'hF8, 1'b0);   // broken by an invalid lead
        push_byte(8'hFE, 1'b0);
        send_queued();

        drain();
        write_rune('0);
        gap_max = 8;
        run_random(50);

        // Receiver held off while the sender keeps offering
        drain();
        write_rune(31'h7FFFFFFF);
        gap_max = 0;
        -> hold_ev;
        run_random(50);

        // No idling on either side
        drain();
        write_rune(31'($urandom));
        rx_always <= 1'b1;
        run_random(50);

        drain();
        write_rune(RUNE_RESET);
        rx_always <= 1'b0;
        gap_max = 15;
        run_random(50);

        drain();
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
